[rtl/core/pfe_pkg.sv]
package pfe_pkg;

   localparam int DATA_W = 32;
   localparam int CNT_W  = $clog2(DATA_W);

   localparam logic [7:0] SYM_PLUS   = 8'h2B;
   localparam logic [7:0] SYM_MINUS  = 8'h2D;
   localparam logic [7:0] SYM_TIMES  = 8'h2A;
   localparam logic [7:0] SYM_DIVIDE = 8'h2F;
   localparam logic [7:0] SYM_POWER  = 8'h5E;
   localparam logic [7:0] SYM_PAREN  = 8'h28;
   localparam logic [DATA_W-1:0] DIGIT_BASE = 32'd48;

   localparam logic [1:0] ERR_OK    = 2'd0;
   localparam logic [1:0] ERR_UNDER = 2'd1;
   localparam logic [1:0] ERR_OVER  = 2'd2;
   localparam logic [1:0] ERR_DIVZ  = 2'd3;

   typedef struct packed {
      logic [7:0] symbol;
      logic       last;
   } req_word_type;

   typedef struct packed {
      logic signed [31:0] value;
      logic [1:0]         status;
   } rsp_word_type;

   typedef enum logic [2:0] {
      OP_ADD,
      OP_SUB,
      OP_MUL,
      OP_DIV,
      OP_POW,
      OP_ZERO
   } alu_op_type;

   typedef struct packed {
      logic       start;
      alu_op_type op;
   } alu_req_type;

   typedef struct packed {
      logic done;
      logic div_zero;
   } alu_status_type;

   function automatic logic is_operator(logic [7:0] s);
      return (s == SYM_PLUS) || (s == SYM_MINUS) || (s == SYM_TIMES) ||
             (s == SYM_DIVIDE) || (s == SYM_POWER) || (s == SYM_PAREN);
   endfunction

   function automatic alu_op_type sym_to_op(logic [7:0] s);
      alu_op_type op;
      case (s)
         SYM_PLUS:   op = OP_ADD;
         SYM_MINUS:  op = OP_SUB;
         SYM_TIMES:  op = OP_MUL;
         SYM_DIVIDE: op = OP_DIV;
         SYM_POWER:  op = OP_POW;
         default:    op = OP_ZERO;
      endcase
      return op;
   endfunction

   function automatic logic [1:0] first_error(logic [1:0] cur, logic [1:0] code);
      return (cur == ERR_OK) ? code : cur;
   endfunction

endpackage

[rtl/core/pfe_ram.sv]
module pfe_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/pfe_alu.sv]
module pfe_alu (
   input  logic                   clock,
   input  logic                   reset,
   input  pfe_pkg::alu_req_type   alu_req,
   input  logic [31:0]            lhs,
   input  logic [31:0]            rhs,
   output pfe_pkg::alu_status_type alu_status,
   output logic [31:0]            result
);

   import pfe_pkg::*;

   typedef enum logic [5:0] {
      AL_IDLE    = 6'b000001,
      AL_DIV     = 6'b000010,
      AL_SIGN    = 6'b000100,
      AL_POW_MUL = 6'b001000,
      AL_POW_SQR = 6'b010000,
      AL_DONE    = 6'b100000
   } alu_state_type;

   alu_state_type     state_ff, state_in;
   logic [DATA_W-1:0] acc_ff, acc_in;
   logic [DATA_W-1:0] sq_ff, sq_in;
   logic [DATA_W-1:0] rem_ff, rem_in;
   logic [DATA_W-1:0] exp_ff, exp_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              neg_ff, neg_in;
   logic              divz_ff, divz_in;

   logic [DATA_W-1:0] mul_a, mul_b, product;
   logic [DATA_W:0]   shifted, diff;
   logic              ge;
   logic [DATA_W-1:0] lhs_mag, rhs_mag;

   always_comb begin
      case (state_ff)
         AL_POW_MUL: begin
            mul_a = acc_ff;
            mul_b = sq_ff;
         end
         AL_POW_SQR: begin
            mul_a = sq_ff;
            mul_b = sq_ff;
         end
         default: begin
            mul_a = lhs;
            mul_b = rhs;
         end
      endcase
   end

   assign product = mul_a * mul_b;
   assign shifted = {rem_ff, acc_ff[DATA_W-1]};
   assign diff    = shifted - {1'b0, sq_ff};
   assign ge      = !diff[DATA_W];
   assign lhs_mag = lhs[DATA_W-1] ? (~lhs + 32'd1) : lhs;
   assign rhs_mag = rhs[DATA_W-1] ? (~rhs + 32'd1) : rhs;

   always_comb begin
      state_in = state_ff;
      acc_in   = acc_ff;
      sq_in    = sq_ff;
      rem_in   = rem_ff;
      exp_in   = exp_ff;
      cnt_in   = cnt_ff;
      neg_in   = neg_ff;
      divz_in  = divz_ff;
      case (state_ff)
         AL_IDLE: begin
            if (alu_req.start) begin
               divz_in  = 1'b0;
               state_in = AL_DONE;
               case (alu_req.op)
                  OP_ADD: acc_in = lhs + rhs;
                  OP_SUB: acc_in = lhs - rhs;
                  OP_MUL: acc_in = product;
                  OP_DIV: begin
                     if (rhs == '0) begin
                        acc_in  = '0;
                        divz_in = 1'b1;
                     end else begin
                        acc_in   = lhs_mag;
                        sq_in    = rhs_mag;
                        rem_in   = '0;
                        cnt_in   = '0;
                        neg_in   = lhs[DATA_W-1] ^ rhs[DATA_W-1];
                        state_in = AL_DIV;
                     end
                  end
                  OP_POW: begin
                     if (rhs[DATA_W-1]) begin
                        if (lhs == 32'd1) begin
                           acc_in = 32'd1;
                        end else if (lhs == '1) begin
                           acc_in = rhs[0] ? '1 : 32'd1;
                        end else begin
                           acc_in = '0;
                        end
                     end else begin
                        acc_in   = 32'd1;
                        sq_in    = lhs;
                        exp_in   = rhs;
                        state_in = AL_POW_MUL;
                     end
                  end
                  default: acc_in = '0;
               endcase
            end
         end
         AL_DIV: begin
            rem_in = ge ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
            acc_in = {acc_ff[DATA_W-2:0], ge};
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(DATA_W - 1)) begin
               state_in = AL_SIGN;
            end
         end
         AL_SIGN: begin
            acc_in   = neg_ff ? (~acc_ff + 32'd1) : acc_ff;
            state_in = AL_DONE;
         end
         AL_POW_MUL: begin
            if (exp_ff[0]) begin
               acc_in = product;
            end
            state_in = AL_POW_SQR;
         end
         AL_POW_SQR: begin
            sq_in  = product;
            exp_in = exp_ff >> 1;
            if (exp_ff[DATA_W-1:1] == '0) begin
               state_in = AL_DONE;
            end else begin
               state_in = AL_POW_MUL;
            end
         end
         AL_DONE: state_in = AL_IDLE;
         default: state_in = AL_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= AL_IDLE;
         divz_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         divz_ff  <= divz_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      sq_ff  <= sq_in;
      rem_ff <= rem_in;
      exp_ff <= exp_in;
      cnt_ff <= cnt_in;
      neg_ff <= neg_in;
   end

   assign alu_status.done     = (state_ff == AL_DONE);
   assign alu_status.div_zero = divz_ff;
   assign result              = acc_ff;

endmodule

[rtl/core/postfix_expression_evaluator_core.sv]
// Channel  Ports                          Word                    Direction
// req      req_valid req_ready req_word   symbol[7:0], last       in
// rsp      rsp_valid rsp_ready rsp_word   value[31:0], status[1:0] out
//
// Digit: pushed in IDLE. + - * ( / ^ : lower operand read in IDLE, ALU
// started in LOAD, written back in EXEC. / : one-bit-per-cycle restoring
// divider, skipped for a zero divisor. ^ : square and multiply sharing one
// 32x32 multiplier, once per exponent bit (min. once); none if negative.
// The result register lets the next word enter while a result waits; a last
// word stalls in its final cycle only while rsp is still held.
// Synchronous reset clears the stack pointer and status; the stack memory is
// not cleared.
module postfix_expression_evaluator_core #(
   parameter int STACK_DEPTH = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  pfe_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output pfe_pkg::rsp_word_type rsp_word
);

   import pfe_pkg::*;

   localparam int SP_W   = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_W = $clog2(STACK_DEPTH);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_LOAD = 4'b0010,
      ST_EXEC = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   state_type         state_ff, state_in;
   logic [SP_W-1:0]   sp_ff, sp_in;
   logic [1:0]        err_ff, err_in;
   logic [DATA_W-1:0] tos_ff, tos_in;
   alu_op_type        op_ff, op_in;
   logic              last_ff, last_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_word_type      rsp_word_ff, rsp_word_in;

   logic              wr_en, rd_en;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic [DATA_W-1:0] wr_data, rd_data;
   logic [SP_W-1:0]   sp_m2;
   logic [DATA_W-1:0] digit;
   logic [1:0]        final_status;

   alu_req_type       alu_req;
   alu_status_type    alu_status;
   logic [DATA_W-1:0] alu_result;

   pfe_ram #(
      .WIDTH(DATA_W),
      .DEPTH(STACK_DEPTH)
   ) u_stack (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   pfe_alu u_alu (
      .clock     (clock),
      .reset     (reset),
      .alu_req   (alu_req),
      .lhs       (rd_data),
      .rhs       (tos_ff),
      .alu_status(alu_status),
      .result    (alu_result)
   );

   assign sp_m2        = sp_ff - SP_W'(2);
   assign digit        = {24'b0, req_word.symbol} - DIGIT_BASE;
   assign final_status = first_error(err_ff, (sp_ff == '0) ? ERR_UNDER : ERR_OK);

   always_comb begin
      state_in     = state_ff;
      sp_in        = sp_ff;
      err_in       = err_ff;
      tos_in       = tos_ff;
      op_in        = op_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      wr_en        = 1'b0;
      wr_addr      = sp_ff[ADDR_W-1:0];
      wr_data      = digit;
      rd_en        = 1'b0;
      rd_addr      = sp_m2[ADDR_W-1:0];
      alu_req      = '{start: 1'b0, op: op_ff};

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               last_in = req_word.last;
               op_in   = sym_to_op(req_word.symbol);
               if (is_operator(req_word.symbol)) begin
                  if (sp_ff < SP_W'(2)) begin
                     err_in   = first_error(err_ff, ERR_UNDER);
                     state_in = ST_DONE;
                  end else begin
                     rd_en    = 1'b1;
                     state_in = ST_LOAD;
                  end
               end else begin
                  if (sp_ff == SP_W'(STACK_DEPTH)) begin
                     err_in = first_error(err_ff, ERR_OVER);
                  end else begin
                     wr_en  = 1'b1;
                     tos_in = digit;
                     sp_in  = sp_ff + SP_W'(1);
                  end
                  state_in = ST_DONE;
               end
            end
         end
         ST_LOAD: begin
            alu_req.start = 1'b1;
            state_in      = ST_EXEC;
         end
         ST_EXEC: begin
            if (alu_status.done) begin
               wr_en   = 1'b1;
               wr_addr = sp_m2[ADDR_W-1:0];
               wr_data = alu_result;
               tos_in  = alu_result;
               sp_in   = sp_ff - SP_W'(1);
               if (alu_status.div_zero) begin
                  err_in = first_error(err_ff, ERR_DIVZ);
               end
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!last_ff) begin
               state_in = ST_IDLE;
            end else if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in       = 1'b1;
               rsp_word_in.status = final_status;
               rsp_word_in.value  = (final_status == ERR_OK) ? tos_ff : '0;
               sp_in              = '0;
               err_in             = ERR_OK;
               state_in           = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sp_ff        <= '0;
         err_ff       <= ERR_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sp_ff        <= sp_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tos_ff      <= tos_in;
      op_ff       <= op_in;
      last_ff     <= last_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

[rtl/core/pfe_checker.sv]
module pfe_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input pfe_pkg::rsp_word_type rsp_word
);

   import pfe_pkg::*;

   a_reset_clears_rsp: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))
      else $error("stalled rsp word changed");

   a_error_zero_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_word.status != ERR_OK) |-> (rsp_word.value == 0))
      else $error("nonzero value with error status");

   a_one_word_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("req accepted on consecutive cycles");

   a_rsp_not_at_accept: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_valid && req_ready))
      else $error("result raised right after accept");

endmodule

bind postfix_expression_evaluator_core pfe_checker u_pfe_checker (.*);

[tb/sv/testbench.sv]
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import pfe_pkg::*;

   localparam int STACK_DEPTH = 16;
   localparam int WORD_TARGET = 1350;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   req_word_type req_word = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   rsp_word_type rsp_word;

   req_word_type pending_words[$];
   rsp_word_type expected_results[$];

   logic [31:0] operand_stack [STACK_DEPTH];
   int          stack_depth = 0;
   logic [1:0]  status_code = ERR_OK;

   int   mismatch_count = 0;
   int   accepted_count = 0;
   logic req_sent = 1'b0;
   int   burst_left = 0;
   int   gap_left = 0;
   int   ready_phase = 0;
   int   ready_mode = 0;
   bit   hold_off = 1'b0;

   postfix_expression_evaluator_core #(
      .STACK_DEPTH(STACK_DEPTH)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_word(req_word),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_word(rsp_word)
   );

   always #4 clock = ~clock;

   function automatic void note_error(logic [1:0] code);
      if (status_code == ERR_OK) begin
         status_code = code;
      end
   endfunction

   function automatic void push_operand(logic [31:0] v);
      if (stack_depth >= STACK_DEPTH) begin
         note_error(ERR_OVER);
      end else begin
         operand_stack[stack_depth] = v;
         stack_depth++;
      end
   endfunction

   function automatic bit evaluate_symbol(input req_word_type w, output rsp_word_type answer);
      logic [31:0] lhs;
      logic [31:0] rhs;
      logic [31:0] r;
      logic [31:0] ua;
      logic [31:0] ub;
      logic [31:0] q;
      logic [31:0] sq;
      int          i;
      answer = '0;
      case (w.symbol)
         SYM_PLUS, SYM_MINUS, SYM_TIMES, SYM_DIVIDE, SYM_POWER, SYM_PAREN: begin
            if (stack_depth < 2) begin
               note_error(ERR_UNDER);
            end else begin
               rhs = operand_stack[stack_depth - 1];
               lhs = operand_stack[stack_depth - 2];
               stack_depth -= 2;
               r = '0;
               case (w.symbol)
                  SYM_PLUS:  r = lhs + rhs;
                  SYM_MINUS: r = lhs - rhs;
                  SYM_TIMES: r = lhs * rhs;
                  SYM_DIVIDE: begin
                     if (rhs == '0) begin
                        note_error(ERR_DIVZ);
                     end else begin
                        ua = lhs[31] ? 32'd0 - lhs : lhs;
                        ub = rhs[31] ? 32'd0 - rhs : rhs;
                        q  = ua / ub;
                        r  = (lhs[31] ^ rhs[31]) ? 32'd0 - q : q;
                     end
                  end
                  SYM_POWER: begin
                     if (rhs[31]) begin
                        if (lhs == 32'd1) begin
                           r = 32'd1;
                        end else if (lhs == '1) begin
                           r = rhs[0] ? '1 : 32'd1;
                        end else begin
                           r = '0;
                        end
                     end else begin
                        r  = 32'd1;
                        sq = lhs;
                        for (i = 0; i < 31; i++) begin
                           if (rhs[i]) begin
                              r = r * sq;
                           end
                           sq = sq * sq;
                        end
                     end
                  end
                  default: r = '0;
               endcase
               push_operand(r);
            end
         end
         default: push_operand({24'd0, w.symbol} - DIGIT_BASE);
      endcase
      if (!w.last) begin
         return 1'b0;
      end
      if (stack_depth == 0) begin
         note_error(ERR_UNDER);
      end
      if (status_code == ERR_OK) begin
         answer.value = operand_stack[stack_depth - 1];
      end
      answer.status = status_code;
      stack_depth = 0;
      status_code = ERR_OK;
      return 1'b1;
   endfunction

   function automatic logic [7:0] pick_operator();
      logic [7:0] s;
      case ($urandom_range(0, 5))
         0:       s = SYM_PLUS;
         1:       s = SYM_MINUS;
         2:       s = SYM_TIMES;
         3:       s = SYM_DIVIDE;
         4:       s = SYM_POWER;
         default: s = SYM_PAREN;
      endcase
      return s;
   endfunction

   function automatic logic [7:0] pick_operand();
      logic [7:0] s;
      bit         clash;
      do begin
         if ($urandom_range(0, 4) < 3) begin
            s = 8'($urandom_range(48, 57));
         end else begin
            s = 8'($urandom_range(0, 255));
         end
         case (s)
            SYM_PLUS, SYM_MINUS, SYM_TIMES, SYM_DIVIDE, SYM_POWER, SYM_PAREN: clash = 1'b1;
            default: clash = 1'b0;
         endcase
      end while (clash);
      return s;
   endfunction

   task automatic queue_symbol(input logic [7:0] sym, input logic last);
      req_word_type w;
      w.symbol = sym;
      w.last   = last;
      pending_words.push_back(w);
   endtask

   task automatic queue_expression(input bit broken);
      logic [7:0] syms[$];
      int         depth;
      int         target;
      int         n;
      int         k;
      depth = 0;
      n = 0;
      if (broken) begin
         target = $urandom_range(1, 30);
         for (n = 0; n < target; n++) begin
            case ($urandom_range(0, 2))
               0:       syms.push_back(pick_operator());
               1:       syms.push_back(pick_operand());
               default: syms.push_back(8'($urandom_range(0, 255)));
            endcase
         end
      end else begin
         target = $urandom_range(1, 24);
         while (n < target || depth != 1) begin
            if (depth < 2 ||
                (n < target && depth < STACK_DEPTH && $urandom_range(0, 2) != 0)) begin
               syms.push_back(pick_operand());
               depth++;
            end else begin
               syms.push_back(pick_operator());
               depth--;
            end
            n++;
         end
      end
      for (k = 0; k < syms.size(); k++) begin
         queue_symbol(syms[k], k == syms.size() - 1);
      end
   endtask

   task automatic report_mismatch(input string what);
      mismatch_count++;
      $display("[%0t] mismatch: %s", $realtime, what);
   endtask

   // sender: bursts with random gaps
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_sent) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_words.size() > 0) begin
            req_valid <= 1'b1;
            req_word  <= pending_words[0];
            if (burst_left > 1) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 24);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver: its own stall pattern, plus the long hold-off
   always @(negedge clock) begin
      if (reset || hold_off) begin
         rsp_ready <= 1'b0;
      end else begin
         case (ready_mode)
            0:       rsp_ready <= 1'b1;
            1:       rsp_ready <= 1'($urandom_range(0, 1));
            default: rsp_ready <= (ready_phase % 4 == 0);
         endcase
         ready_phase++;
         if (ready_phase % 64 == 0) begin
            ready_mode = $urandom_range(0, 2);
         end
      end
   end

   always @(posedge clock) begin : accept_and_check
      rsp_word_type predicted;
      rsp_word_type got;
      req_sent <= !reset && req_valid && req_ready;
      if (!reset) begin
         if (req_valid && req_ready) begin
            if (evaluate_symbol(req_word, predicted)) begin
               expected_results.push_back(predicted);
            end
            void'(pending_words.pop_front());
            accepted_count++;
         end
         if (rsp_valid && rsp_ready) begin
            got = rsp_word;
            if (expected_results.size() == 0) begin
               report_mismatch($sformatf("unexpected word value=%0d status=%0d",
                                         got.value, got.status));
            end else begin
               predicted = expected_results.pop_front();
               if (got.value !== predicted.value) begin
                  report_mismatch($sformatf("value %0d, predicted %0d",
                                            got.value, predicted.value));
               end
               if (got.status !== predicted.status) begin
                  report_mismatch($sformatf("status %0d, predicted %0d",
                                            got.status, predicted.status));
               end
            end
         end
      end
   end

   // hold the receiver off while the sender keeps going
   initial begin
      wait (accepted_count >= 400);
      @(posedge clock);
      hold_off = 1'b1;
      repeat (300) @(posedge clock);
      hold_off = 1'b0;
   end

   initial begin
      #10ms;
      $display("postfix_expression_evaluator_core regression: fail");
      $finish;
   end

   initial begin
      queue_symbol(8'hFF, 1'b0);
      queue_symbol(8'h00, 1'b0);
      queue_symbol(SYM_PLUS, 1'b1);

      queue_symbol("2", 1'b0);
      queue_symbol("O", 1'b0);
      queue_symbol(SYM_POWER, 1'b0);
      queue_symbol("0", 1'b0);
      queue_symbol("1", 1'b0);
      queue_symbol(SYM_MINUS, 1'b0);
      queue_symbol(SYM_DIVIDE, 1'b1);

      queue_symbol(" ", 1'b0);
      queue_symbol("5", 1'b0);
      queue_symbol(SYM_DIVIDE, 1'b0);
      queue_symbol("3", 1'b0);
      queue_symbol(SYM_TIMES, 1'b0);
      queue_symbol("0", 1'b0);
      queue_symbol(SYM_DIVIDE, 1'b1);

      queue_symbol("1", 1'b0);
      queue_symbol(".", 1'b0);
      queue_symbol(SYM_POWER, 1'b0);
      queue_symbol("0", 1'b0);
      queue_symbol("0", 1'b0);
      queue_symbol(SYM_POWER, 1'b0);
      queue_symbol(SYM_PLUS, 1'b1);

      queue_symbol(SYM_PLUS, 1'b1);

      queue_symbol("9", 1'b0);
      queue_symbol("7", 1'b0);
      queue_symbol("6", 1'b0);
      queue_symbol(SYM_PAREN, 1'b1);

      while (pending_words.size() < WORD_TARGET) begin
         queue_expression($urandom_range(0, 99) < 15);
      end

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_words.size() != 0 || expected_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (100) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("postfix_expression_evaluator_core regression: pass");
      end else begin
         $display("postfix_expression_evaluator_core regression: fail");
      end
      $finish;
   end

endmodule

[files.f]
rtl/core/pfe_pkg.sv
rtl/core/pfe_ram.sv
rtl/core/pfe_alu.sv
rtl/core/postfix_expression_evaluator_core.sv
rtl/core/pfe_checker.sv
tb/sv/testbench.sv
